/* src/rde_pkg.sv */
// Shared constants, types and codes for the radix digit emitter.
package rde_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_RADIX   = 16;
  localparam int NUM_SYMS    = 16;
  localparam int SYM_W       = 8;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;

  // digit count must hold VALUE_WIDTH itself (radix two, most negative value)
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W = $clog2(VALUE_WIDTH);

  // long division by the radix, DIV_STEPS quotient bits per cycle
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int WORK_W     = DIV_CYCLES * DIV_STEPS;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  localparam logic [SYM_W-1:0] MINUS_SYM = 8'h2D;
  localparam logic [SYM_W-1:0] PLUS_SYM  = 8'h2B;

  typedef logic [NUM_SYMS-1:0][SYM_W-1:0] alpha_t;

  typedef enum logic [1:0] {
    REG_RADIX  = 2'd0,
    REG_SYM_LO = 2'd1,
    REG_SYM_HI = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture value, clear digit count
    logic div;    // one division cycle
    logic sign;   // put out minus symbol
    logic emit;   // put out the digit read from the store
    logic inval;  // put out the invalid-alphabet word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;    // final cycle of one digit's division
    logic quo_zero;    // quotient after this cycle is zero
    logic neg;         // captured value is negative
    logic last_digit;  // one digit left to emit
  } sts_t;

endpackage

/* src/rde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rde_regs.sv */
// APB configuration registers and the registered alphabet check.
module rde_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rde_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rde_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rde_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [rde_pkg::RADIX_W-1:0]      radix_o,
  output rde_pkg::alpha_t                  alpha_o,
  output logic                             alpha_ok_o
);

  logic [rde_pkg::RADIX_W-1:0]    radix_q;
  logic [rde_pkg::CFG_DATA_W-1:0] sym_lo_q;
  logic [rde_pkg::CFG_DATA_W-1:0] sym_hi_q;
  logic                           ok_q;
  logic                           ok_d;
  logic                           wr_en;
  rde_pkg::cfg_reg_e              reg_sel;
  rde_pkg::alpha_t                alpha;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = rde_pkg::cfg_reg_e'(paddr[rde_pkg::CFG_ADDR_W-1:3]);
  assign alpha   = {sym_hi_q, sym_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= '0;
      sym_lo_q <= '0;
      sym_hi_q <= '0;
      ok_q     <= 1'b0;
    end else begin
      ok_q <= ok_d;
      if (wr_en) begin
        case (reg_sel)
          rde_pkg::REG_RADIX:  radix_q  <= pwdata[rde_pkg::RADIX_W-1:0];
          rde_pkg::REG_SYM_LO: sym_lo_q <= pwdata;
          rde_pkg::REG_SYM_HI: sym_hi_q <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_sel)
      rde_pkg::REG_RADIX:  prdata = rde_pkg::CFG_DATA_W'(radix_q);
      rde_pkg::REG_SYM_LO: prdata = sym_lo_q;
      rde_pkg::REG_SYM_HI: prdata = sym_hi_q;
      default:             prdata = '0;
    endcase
  end

  // radix range check, all-pairs duplicate check plus sign symbols, masked to the live radix
  always_comb begin
    logic bad;
    bad = (radix_q < rde_pkg::RADIX_W'(2)) ||
          (radix_q > rde_pkg::RADIX_W'(rde_pkg::MAX_RADIX));
    for (int i = 0; i < rde_pkg::NUM_SYMS; i++) begin
      if (rde_pkg::RADIX_W'(i) < radix_q) begin
        if (alpha[i] == rde_pkg::MINUS_SYM || alpha[i] == rde_pkg::PLUS_SYM) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < rde_pkg::NUM_SYMS; j++) begin
          if (rde_pkg::RADIX_W'(j) < radix_q && alpha[j] == alpha[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
    ok_d = !bad;
  end

  assign radix_o    = radix_q;
  assign alpha_o    = alpha;
  assign alpha_ok_o = ok_q;

endmodule

/* src/rde_ctrl.sv */
// Sequencer: check, divide digit by digit, then emit sign and digits; a bad alphabet gives the invalid word.
module rde_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          alpha_ok_i,
  input  rde_pkg::sts_t sts_i,
  output rde_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  rde_pkg::state_e state_q;
  rde_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rde_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      rde_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = rde_pkg::ST_CHECK;
        end
      end
      rde_pkg::ST_CHECK: begin
        if (alpha_ok_i) begin
          state_d = rde_pkg::ST_DIV;
        end else begin
          cmd_o.inval = 1'b1;
          state_d     = rde_pkg::ST_IDLE;
        end
      end
      rde_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last && sts_i.quo_zero) begin
          state_d = sts_i.neg ? rde_pkg::ST_SIGN : rde_pkg::ST_READ;
        end
      end
      rde_pkg::ST_SIGN: begin
        cmd_o.sign = 1'b1;
        state_d    = rde_pkg::ST_EMIT;
      end
      rde_pkg::ST_READ: begin
        state_d = rde_pkg::ST_EMIT;
      end
      rde_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.last_digit) begin
          state_d = rde_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rde_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/rde_dp.sv */
// Datapath: magnitude, radix divider, digit store and output word register.
module rde_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rde_pkg::cmd_t                     cmd_i,
  output rde_pkg::sts_t                     sts_o,
  input  logic signed [rde_pkg::VALUE_WIDTH-1:0] value_i,
  input  logic [rde_pkg::RADIX_W-1:0]       radix_i,
  input  rde_pkg::alpha_t                   alpha_i,
  output logic                              valid_o,
  output logic [rde_pkg::SYM_W-1:0]         symbol_o,
  output logic                              last_o,
  output logic                              invalid_o
);

  logic [rde_pkg::WORK_W-1:0]      work_q;
  logic [rde_pkg::WORK_W-1:0]      quo_nx;
  logic [rde_pkg::DIGIT_W-1:0]     rem_q;
  logic [rde_pkg::DIGIT_W-1:0]     rem_nx;
  logic [rde_pkg::DIV_CNT_W-1:0]   divcnt_q;
  logic [rde_pkg::CNT_W-1:0]       count_q;
  logic                            neg_q;
  logic                            div_last;
  logic [rde_pkg::VALUE_WIDTH-1:0] mag;
  logic [rde_pkg::CNT_W-1:0]       raddr_full;
  logic [rde_pkg::DIGIT_W-1:0]     rdata;
  logic                            wr_en;

  logic                            valid_q;
  logic [rde_pkg::SYM_W-1:0]       symbol_q;
  logic                            last_q;
  logic                            invalid_q;

  // unsigned magnitude; the most negative value maps to 2^(W-1)
  assign mag = value_i[rde_pkg::VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;

  // DIV_STEPS restoring steps; remainder stays below the radix (<= 16)
  always_comb begin
    logic [rde_pkg::DIGIT_W-1:0]   r;
    logic [rde_pkg::DIGIT_W:0]     t;
    logic [rde_pkg::DIV_STEPS-1:0] qb;
    r  = rem_q;
    qb = '0;
    for (int k = 0; k < rde_pkg::DIV_STEPS; k++) begin
      t = {r, work_q[rde_pkg::WORK_W-1-k]};
      if (t >= radix_i) begin
        r = rde_pkg::DIGIT_W'(t - radix_i);
        qb[rde_pkg::DIV_STEPS-1-k] = 1'b1;
      end else begin
        r = t[rde_pkg::DIGIT_W-1:0];
      end
    end
    rem_nx = r;
    quo_nx = (work_q << rde_pkg::DIV_STEPS) | rde_pkg::WORK_W'(qb);
  end

  assign div_last = (divcnt_q == rde_pkg::DIV_CNT_W'(rde_pkg::DIV_CYCLES - 1));
  assign wr_en    = cmd_i.div & div_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      divcnt_q <= '0;
    end else if (cmd_i.load || cmd_i.inval) begin
      count_q  <= '0;
      divcnt_q <= '0;
    end else if (cmd_i.div) begin
      divcnt_q <= div_last ? '0 : divcnt_q + 1'b1;
      if (div_last) begin
        count_q <= count_q + 1'b1;
      end
    end else if (cmd_i.emit) begin
      count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q <= rde_pkg::WORK_W'(mag);
      rem_q  <= '0;
      neg_q  <= value_i[rde_pkg::VALUE_WIDTH-1];
    end else if (cmd_i.div) begin
      work_q <= quo_nx;
      rem_q  <= div_last ? '0 : rem_nx;
    end
  end

  // read one ahead: while emitting digit n, fetch digit n-1
  assign raddr_full = count_q - (cmd_i.emit ? rde_pkg::CNT_W'(2) : rde_pkg::CNT_W'(1));

  rde_ram #(
    .WIDTH (rde_pkg::DIGIT_W),
    .DEPTH (rde_pkg::VALUE_WIDTH)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[rde_pkg::ADDR_W-1:0]),
    .wdata_i (rem_nx),
    .raddr_i (raddr_full[rde_pkg::ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.sign | cmd_i.emit | cmd_i.inval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sign) begin
      symbol_q  <= rde_pkg::MINUS_SYM;
      last_q    <= 1'b0;
      invalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      symbol_q  <= alpha_i[rdata];
      last_q    <= (count_q == rde_pkg::CNT_W'(1));
      invalid_q <= 1'b0;
    end else if (cmd_i.inval) begin
      symbol_q  <= '0;
      last_q    <= 1'b1;
      invalid_q <= 1'b1;
    end
  end

  assign sts_o.div_last   = div_last;
  assign sts_o.quo_zero   = (quo_nx == '0);
  assign sts_o.neg        = neg_q;
  assign sts_o.last_digit = (count_q == rde_pkg::CNT_W'(1));

  assign valid_o   = valid_q;
  assign symbol_o  = symbol_q;
  assign last_o    = last_q;
  assign invalid_o = invalid_q;

endmodule

/* src/radix_digit_emitter.sv */
// Top level of the radix digit emitter: registers, sequencer and datapath.
//
// Converts a signed 32-bit value into alphabet symbols, most significant
// digit first, a leading minus symbol for negative values. Pulse start while
// busy is low to hand over value_i; each output word then shows on
// symbol_o/last_o/invalid_o for exactly one cycle with valid_o high, and it
// cannot be held off. last_o marks the final word of a value. If the alphabet
// is bad (radix outside 2..16, a '+' or '-' symbol, or any two equal symbols
// among the first radix entries) a single word with symbol 0, last and
// invalid set comes out instead. For each value the block runs an alphabet
// check, then the radix divider once per digit (8 quotient bits per cycle
// over the 32-bit magnitude), then a step to prime the digit store read
// (or to send the minus word), then it puts out one word per cycle.
// Registers: radix at 0x00, symbols 0..7 at 0x08, symbols 8..15 at 0x10,
// 64-bit APB data; write only while idle.
module radix_digit_emitter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rde_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [rde_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [rde_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [rde_pkg::VALUE_WIDTH-1:0] value_i,
  output logic                                   valid_o,
  output logic [rde_pkg::SYM_W-1:0]              symbol_o,
  output logic                                   last_o,
  output logic                                   invalid_o
);

  logic [rde_pkg::RADIX_W-1:0] radix;
  rde_pkg::alpha_t             alpha;
  logic                        alpha_ok;
  rde_pkg::cmd_t               cmd;
  rde_pkg::sts_t               sts;

  // config file; alpha_ok is registered and consumed in the cycle after start
  rde_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .radix_o    (radix),
    .alpha_o    (alpha),
    .alpha_ok_o (alpha_ok)
  );

  rde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .alpha_ok_i (alpha_ok),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  rde_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .value_i   (value_i),
    .radix_i   (radix),
    .alpha_i   (alpha),
    .valid_o   (valid_o),
    .symbol_o  (symbol_o),
    .last_o    (last_o),
    .invalid_o (invalid_o)
  );

  // invalid word is always the final word of its run, with symbol 0
  a_inval_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && invalid_o |-> last_o && symbol_o == '0)
    else $error("invalid word without last or with nonzero symbol");

  // an accepted start always makes the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("start accepted but block not busy");

  // a non-final word means more words follow, so the sequencer is still busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy)
    else $error("non-final word while idle");

  // a final word is never directly followed by another word
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o)
    else $error("word directly after final word");

endmodule

/* test/radix_digit_emitter_check.sv */
// Checker for the radix digit emitter: follows the register port and the
// start handshake, predicts every output word and compares it on arrival.
module radix_digit_emitter_check
  import rde_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_W-1:0]         paddr,
  input  logic [CFG_DATA_W-1:0]         pwdata,
  input  logic                          pready,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          valid_o,
  input  logic [SYM_W-1:0]              symbol_o,
  input  logic                          last_o,
  input  logic                          invalid_o,
  output int                            mismatches,
  output int                            words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             invalid;
  } emitted_word_t;

  // shadow copy of the block's registers
  logic [RADIX_W-1:0] radix_q;
  logic [63:0]        sym_lo_q;
  logic [63:0]        sym_hi_q;

  emitted_word_t expected_words[$];
  int            err_count;

  // Alphabet check, then the minus word for negative v and the digits of |v|, most significant first.
  function automatic void queue_conversion(logic signed [VALUE_WIDTH-1:0] v);
    alpha_t              alpha;
    logic [VALUE_WIDTH-1:0] mag;
    logic [DIGIT_W-1:0]  digits[$];
    bit                  ok;
    bit                  neg;
    int                  i;
    int                  j;
    alpha = {sym_hi_q, sym_lo_q};
    ok = (radix_q >= 2) && (radix_q <= MAX_RADIX);
    if (ok) begin
      for (i = 0; i < radix_q; i++) begin
        if (alpha[i] == MINUS_SYM || alpha[i] == PLUS_SYM) ok = 0;
        for (j = i + 1; j < radix_q; j++)
          if (alpha[j] == alpha[i]) ok = 0;
      end
    end
    if (!ok) begin
      expected_words.push_back('{symbol: '0, last: 1'b1, invalid: 1'b1});
      return;
    end
    neg = v[VALUE_WIDTH-1];
    // unsigned negate: the most negative value comes out as 2**31
    mag = neg ? (~v + 1'b1) : v;
    do begin
      digits.push_back(DIGIT_W'(mag % radix_q));
      mag = mag / radix_q;
    end while (mag != 0);
    if (neg) expected_words.push_back('{symbol: MINUS_SYM, last: 1'b0, invalid: 1'b0});
    for (i = digits.size() - 1; i >= 0; i--)
      expected_words.push_back('{symbol: alpha[digits[i]], last: (i == 0), invalid: 1'b0});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    emitted_word_t want;
    if (!rst_ni) begin
      radix_q   = '0;
      sym_lo_q  = '0;
      sym_hi_q  = '0;
      err_count = 0;
      expected_words.delete();
      mismatches <= 0;
      words_due  <= 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr >> 3)
          REG_RADIX:  radix_q  = pwdata[RADIX_W-1:0];
          REG_SYM_LO: sym_lo_q = pwdata;
          REG_SYM_HI: sym_hi_q = pwdata;
          default: ;
        endcase
      end
      // output word: older items first, so compare before queueing a new one
      if (valid_o) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: symbol %h last %0b invalid %0b",
                 symbol_o, last_o, invalid_o);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          if (symbol_o !== want.symbol) begin
            $error("symbol: expected %h, got %h", want.symbol, symbol_o);
            err_count++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            err_count++;
          end
          if (invalid_o !== want.invalid) begin
            $error("invalid: expected %0b, got %0b", want.invalid, invalid_o);
            err_count++;
          end
        end
      end
      if (start && !busy) queue_conversion(value_i);
      mismatches <= err_count;
      words_due  <= expected_words.size();
    end
  end

endmodule

/* test/radix_digit_emitter_test.sv */
// Testbench top for the radix digit emitter: clock, reset, stimulus, verdict.
module radix_digit_emitter_test;
  import rde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_VALUES = 140;
  // cycles with no handshake at all before the run is declared hung; it must
  // exceed the slowest conversion (32 binary digits) plus the longest sender gap
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 20;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [CFG_ADDR_W-1:0]         paddr;
  logic [CFG_DATA_W-1:0]         pwdata;
  logic [CFG_DATA_W-1:0]         prdata;
  logic                          pready;
  logic                          start;
  logic                          busy;
  logic signed [VALUE_WIDTH-1:0] value_i;
  logic                          valid_o;
  logic [SYM_W-1:0]              symbol_o;
  logic                          last_o;
  logic                          invalid_o;

  int mismatches;
  int words_due;
  int quiet_cycles;
  int values_sent;
  bit calm;  // phase with back-to-back values, no sender gaps

  radix_digit_emitter DUT (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .value_i,
    .valid_o, .symbol_o, .last_o, .invalid_o
  );

  radix_digit_emitter_check u_check (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .start, .busy, .value_i,
    .valid_o, .symbol_o, .last_o, .invalid_o,
    .mismatches, .words_due
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Watchdog: any value taken, word put out or register written counts as
  // progress; a long run of cycles with none of them means a hang.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (psel && penable && pwrite))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Sender gap in cycles: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lower start and hold off until every predicted word has come out and
  // the block is idle. Registers are only touched after this.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    do @(negedge clk_i); while (words_due != 0 || busy);
  endtask

  // Register write: setup cycle, then access cycle. Inputs move on the
  // falling edge; the write lands on the rising edge inside the access cycle.
  task automatic cfg_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_alphabet(logic [RADIX_W-1:0] r, logic [63:0] lo, logic [63:0] hi);
    drain();
    cfg_write(REG_RADIX, CFG_DATA_W'(r));
    cfg_write(REG_SYM_LO, lo);
    cfg_write(REG_SYM_HI, hi);
  endtask

  // Offer one value. start stays high after the handshake; the next call
  // either keeps it high (no gap) or drops it for the gap, so it never gets
  // two assignments on the same edge.
  task automatic send_value(logic signed [VALUE_WIDTH-1:0] v);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    values_sent++;
  endtask

  // Sixteen distinct symbols, none of them a sign.
  function automatic alpha_t random_alphabet();
    alpha_t     a;
    bit         seen[256];
    logic [7:0] b;
    for (int i = 0; i < NUM_SYMS; i++) begin
      do b = 8'($urandom_range(0, 255));
      while (b == MINUS_SYM || b == PLUS_SYM || seen[b]);
      seen[b] = 1'b1;
      a[i] = b;
    end
    return a;
  endfunction

  // Values for radix r: full 32-bit noise, small numbers, powers of the
  // radix and their neighbors (digit-count boundaries), and the extremes.
  function automatic logic signed [VALUE_WIDTH-1:0] random_value(int r);
    longint pow;
    longint v;
    int     k;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = -1;
          2: v = 64'sh7FFF_FFFF;
          default: v = -64'sh8000_0000;
        endcase
      end
      1, 2: v = $urandom_range(0, r * r * r);
      3, 4: begin
        pow = 1;
        k = $urandom_range(0, 31);
        repeat (k) if (pow * r <= 64'sh8000_0000) pow = pow * r;
        v = pow + $urandom_range(0, 2) - 1;
      end
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return VALUE_WIDTH'(v);
  endfunction

  initial begin
    alpha_t a;
    int     r;
    int     count;
    int     i;
    int     j;
    bit     good;

    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    start   = 1'b0;
    value_i = '0;
    calm    = 1'b0;
    values_sent = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    // radix is zero out of reset: bad alphabet
    send_value(5);
    // radix one: still too few symbols
    set_alphabet(1, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    send_value(-7);

    // decimal
    set_alphabet(10, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    send_value(0);
    send_value(7);
    send_value(-1);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(1000000000);
    send_value(-10);

    // binary: the most negative value is the longest run, minus plus 32 digits
    set_alphabet(2, 64'h0000_0000_0000_3130, 64'h0);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(1);
    send_value(-2);

    // hex, full sixteen symbols
    set_alphabet(16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'shDEAD_BEEF);
    send_value(-16);

    // zero byte as symbol 0; the zero bytes past the radix don't count
    set_alphabet(3, 64'h0000_0000_0042_4100, 64'h0);
    send_value(0);
    send_value(5);

    // radix above sixteen
    set_alphabet(31, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    send_value(42);
    // plus sign at the top of the alphabet
    set_alphabet(12, 64'h3736_3534_3332_3130, 64'h6665_6463_2B61_3938);
    send_value(42);
    // minus sign at symbol 15
    set_alphabet(16, 64'h3736_3534_3332_3130, 64'h2D65_6463_6261_3938);
    send_value(-42);
    // symbol 9 repeats symbol 0: far apart, not neighbors
    set_alphabet(10, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3038);
    send_value(42);
    // the same repeat just past the radix is harmless
    set_alphabet(9, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3038);
    send_value(-80);

    // ---- random part: one alphabet per phase ----
    count = values_sent + RANDOM_VALUES;
    while (values_sent < count) begin
      a = random_alphabet();
      good = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: r = 2;
        1: r = 16;
        default: r = $urandom_range(3, 15);
      endcase
      if (!good) begin
        case ($urandom_range(0, 2))
          0: r = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
          1: a[$urandom_range(0, r - 1)] = $urandom_range(0, 1) ? PLUS_SYM : MINUS_SYM;
          default: begin
            i = $urandom_range(0, r - 2);
            j = $urandom_range(i + 1, r - 1);
            a[j] = a[i];
          end
        endcase
      end
      set_alphabet(RADIX_W'(r), a[7:0], a[15:8]);
      calm = ($urandom_range(0, 3) == 0);
      repeat (good ? $urandom_range(6, 24) : $urandom_range(1, 4)) begin
        // now and then let the block run dry before the next value
        if ($urandom_range(0, 9) == 0) drain();
        send_value(random_value(r));
      end
    end

    // ---- wrap up ----
    calm = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && words_due == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
